FILE: rtl/core/sg3_pkg.sv
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient package
// Shared constants, register indexes and types for the gradient core.
// ----------------------------------------------------------------------------
`default_nettype none

package sg3_pkg;

    localparam int PIX_W        = 8;
    localparam int GRAD_W       = 11;
    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COL_W    = 10;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int RES_SLOTS    = 4;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 4'd0,
        CFG_IMAGE_HEIGHT = 4'd1
    } t_cfg_reg;

    // one line-store word: the two rows above the current one
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_line_word;

    // [row r-2..r][col c-2..c]
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    // control of one pixel on its way to the emit stage
    typedef struct packed {
        logic                 valid;
        logic [RES_SLOTS-1:0] mask;     // results in raster order, bit 0 first
        logic                 row_ge1;
        logic                 row_ge2;
        logic                 col_ge1;
        logic                 col_ge2;
    } t_item_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/sg3_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sg3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/sg3_cfg.sv
// ----------------------------------------------------------------------------
// Sobel 3x3 configuration registers
// Holds image width and height as clamped last-column and last-row values.
// ----------------------------------------------------------------------------
`default_nettype none

module sg3_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sg3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sg3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic      [CW-1:0]                  o_w_last,
    output logic      [RW-1:0]                  o_h_last,
    output logic                                o_restart
);

    localparam int WC = (CW + 1 > sg3_pkg::CFG_WIDTH_W) ? CW + 1 : sg3_pkg::CFG_WIDTH_W;
    localparam int HC = (RW + 1 > sg3_pkg::CFG_HEIGHT_W) ? RW + 1 : sg3_pkg::CFG_HEIGHT_W;
    localparam int W_RST = (sg3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                              : sg3_pkg::WIDTH_RESET;
    localparam int H_RST = (sg3_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : sg3_pkg::HEIGHT_RESET;

    logic [CW-1:0] r_w_last, n_w_last;
    logic [RW-1:0] r_h_last, n_h_last;
    logic [WC-1:0] w_val;
    logic [HC-1:0] h_val;
    logic          wr;
    logic          wr_width;
    logic          wr_height;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;
    assign wr_width    = wr && (i_cfg_index == sg3_pkg::CFG_IMAGE_WIDTH);
    assign wr_height   = wr && (i_cfg_index == sg3_pkg::CFG_IMAGE_HEIGHT);
    assign o_restart   = wr_width || wr_height;

    // zero acts as one, anything above the maximum as the maximum
    always_comb begin
        w_val = WC'(i_cfg_data[sg3_pkg::CFG_WIDTH_W-1:0]);
        h_val = HC'(i_cfg_data[sg3_pkg::CFG_HEIGHT_W-1:0]);
        priority if (w_val == '0) begin
            n_w_last = '0;
        end else if (w_val > WC'(MAX_WIDTH)) begin
            n_w_last = CW'(MAX_WIDTH - 1);
        end else begin
            n_w_last = CW'(w_val - WC'(1));
        end
        priority if (h_val == '0) begin
            n_h_last = '0;
        end else if (h_val > HC'(MAX_HEIGHT)) begin
            n_h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            n_h_last = RW'(h_val - HC'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(W_RST - 1);
            r_h_last <= RW'(H_RST - 1);
        end else begin
            if (wr_width) begin
                r_w_last <= n_w_last;
            end
            if (wr_height) begin
                r_h_last <= n_h_last;
            end
        end
    end

    assign o_w_last = r_w_last;
    assign o_h_last = r_h_last;

endmodule

`default_nettype wire

FILE: rtl/core/sg3_window.sv
// ----------------------------------------------------------------------------
// Sobel 3x3 line stores and window
// Raster counters, input register, line-store RAM and the 3x3 pixel window.
// ----------------------------------------------------------------------------
`default_nettype none

module sg3_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [sg3_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [CW-1:0]             i_w_last,
    input  wire logic [RW-1:0]             i_h_last,
    input  wire logic                      i_restart,
    input  wire logic                      i_ready,
    output sg3_pkg::t_item_ctrl            o_item,
    output logic      [RW-1:0]             o_row,
    output logic      [CW-1:0]             o_col,
    output sg3_pkg::t_window               o_window
);

    logic [CW-1:0]            r_col, n_col;
    logic [RW-1:0]            r_row, n_row;
    sg3_pkg::t_item_ctrl      r_s1, n_s1;
    logic [sg3_pkg::PIX_W-1:0] r_s1_pixel;
    logic [RW-1:0]            r_s1_row;
    logic [CW-1:0]            r_s1_col;
    sg3_pkg::t_window         r_win;
    logic                     r_byp_hit;
    sg3_pkg::t_line_word      r_byp_data;
    sg3_pkg::t_line_word      ram_rdata;
    sg3_pkg::t_line_word      rd;
    sg3_pkg::t_line_word      wr_word;
    logic                     in_acc;
    logic                     s1_adv;
    logic                     ya, yb, xa, xb;

    assign s1_adv     = r_s1.valid && i_ready;
    assign o_in_stall = r_s1.valid && !i_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    // a read at the address written in the same edge sees the old word: forward
    assign rd      = r_byp_hit ? r_byp_data : ram_rdata;
    assign wr_word = '{older: rd.newer, newer: r_s1_pixel};

    sg3_ram #(
        .WIDTH ($bits(sg3_pkg::t_line_word)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (wr_word),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ya = (r_row != '0);
        yb = (r_row == i_h_last);
        xa = (r_col != '0);
        xb = (r_col == i_w_last);
        n_s1.valid   = 1'b1;
        n_s1.mask    = {yb && xb, yb && xa, ya && xb, ya && xa};
        n_s1.row_ge1 = ya;
        n_s1.row_ge2 = (r_row > RW'(1));
        n_s1.col_ge1 = xa;
        n_s1.col_ge2 = (r_col > CW'(1));

        if (r_col == i_w_last) begin
            n_col = '0;
            n_row = (r_row == i_h_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
            r_win <= '0;
        end else begin
            priority if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            priority if (in_acc) begin
                r_s1 <= n_s1;
            end else if (s1_adv) begin
                r_s1.valid <= 1'b0;
            end
            // advance the window by one column
            if (s1_adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= r_s1.row_ge2 ? rd.older : '0;
                r_win[1][2] <= r_s1.row_ge1 ? rd.newer : '0;
                r_win[2][2] <= r_s1_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel <= i_pixel;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_byp_hit  <= s1_adv && (r_s1_col == r_col);
            r_byp_data <= wr_word;
        end
    end

    assign o_item   = r_s1;
    assign o_row    = r_s1_row;
    assign o_col    = r_s1_col;
    assign o_window = r_win;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= i_w_last)
        else $error("column counter beyond last column");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= i_h_last)
        else $error("row counter beyond last row");

endmodule

`default_nettype wire

FILE: rtl/core/sg3_emit.sv
// ----------------------------------------------------------------------------
// Sobel 3x3 emit stage
// Steps through the results one pixel completes and computes each gradient.
// ----------------------------------------------------------------------------
`default_nettype none

module sg3_emit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  sg3_pkg::t_item_ctrl                      i_item,
    input  wire logic        [RW-1:0]                i_row,
    input  wire logic        [CW-1:0]                i_col,
    input  sg3_pkg::t_window                         i_window,
    output logic                                     o_ready,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed      [sg3_pkg::GRAD_W-1:0]   o_grad_x,
    output logic signed      [sg3_pkg::GRAD_W-1:0]   o_grad_y,
    output logic             [sg3_pkg::OUT_ROW_W-1:0] o_out_row,
    output logic             [sg3_pkg::OUT_COL_W-1:0] o_out_col,
    output logic                                     o_last
);

    localparam int GW = sg3_pkg::GRAD_W;
    localparam int NS = sg3_pkg::RES_SLOTS;

    sg3_pkg::t_item_ctrl r_s2;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic                r_o_valid;
    logic signed [GW-1:0] r_gx, r_gy;
    logic [sg3_pkg::OUT_ROW_W-1:0] r_out_row;
    logic [sg3_pkg::OUT_COL_W-1:0] r_out_col;
    logic                r_last;

    logic [NS-1:0]       sel;
    logic [NS-1:0]       rest;
    logic                last;
    logic                out_free;
    logic                emit;
    logic                load;
    logic                y_on_row;
    logic                x_on_col;
    logic [1:0]          rs0, rs1, rs2, cs0, cs1, cs2;
    logic [sg3_pkg::PIX_W-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
    logic [GW-1:0]       sum_l, sum_r, sum_t, sum_b;
    logic signed [GW-1:0] n_gx, n_gy;
    logic [RW-1:0]       y;
    logic [CW-1:0]       x;

    // lowest pending result goes first
    assign sel      = r_s2.mask & (~r_s2.mask + NS'(1));
    assign rest     = r_s2.mask & ~sel;
    assign last     = (rest == '0);
    assign out_free = !r_o_valid || !i_out_stall;
    assign emit     = r_s2.valid && out_free;
    assign o_ready  = !r_s2.valid || (out_free && last);
    assign load     = i_item.valid && o_ready;
    assign y_on_row = sel[2] || sel[3];
    assign x_on_col = sel[1] || sel[3];

    // window taps with edge replication
    always_comb begin
        if (y_on_row) begin
            rs0 = r_s2.row_ge1 ? 2'd1 : 2'd2;
            rs1 = 2'd2;
        end else begin
            rs0 = r_s2.row_ge2 ? 2'd0 : 2'd1;
            rs1 = 2'd1;
        end
        rs2 = 2'd2;
        if (x_on_col) begin
            cs0 = r_s2.col_ge1 ? 2'd1 : 2'd2;
            cs1 = 2'd2;
        end else begin
            cs0 = r_s2.col_ge2 ? 2'd0 : 2'd1;
            cs1 = 2'd1;
        end
        cs2 = 2'd2;

        p00 = i_window[rs0][cs0];
        p01 = i_window[rs0][cs1];
        p02 = i_window[rs0][cs2];
        p10 = i_window[rs1][cs0];
        p12 = i_window[rs1][cs2];
        p20 = i_window[rs2][cs0];
        p21 = i_window[rs2][cs1];
        p22 = i_window[rs2][cs2];

        sum_l = GW'(p00) + (GW'(p10) << 1) + GW'(p20);
        sum_r = GW'(p02) + (GW'(p12) << 1) + GW'(p22);
        sum_t = GW'(p00) + (GW'(p01) << 1) + GW'(p02);
        sum_b = GW'(p20) + (GW'(p21) << 1) + GW'(p22);
        n_gx  = signed'(sum_r - sum_l);
        n_gy  = signed'(sum_b - sum_t);

        y = y_on_row ? r_row : r_row - RW'(1);
        x = x_on_col ? r_col : r_col - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            priority if (load) begin
                r_s2       <= i_item;
                r_s2.valid <= (i_item.mask != '0);
            end else if (emit) begin
                r_s2.mask  <= rest;
                r_s2.valid <= !last;
            end
            priority if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (emit) begin
            r_gx      <= n_gx;
            r_gy      <= n_gy;
            r_out_row <= sg3_pkg::OUT_ROW_W'(y);
            r_out_col <= sg3_pkg::OUT_COL_W'(x);
            r_last    <= last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_grad_x    = r_gx;
    assign o_grad_y    = r_gy;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_last      = r_last;

    a_hold_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_s2.mask) > 1 |-> !o_ready)
        else $error("new pixel taken while several results still pending");

    a_mask_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid && !load |=> (r_s2.mask & ~$past(r_s2.mask)) == '0)
        else $error("pending result set grew without a new pixel");

endmodule

`default_nettype wire

FILE: rtl/core/sobel_gradient_3x3_core.sv
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient core
// Streams gray pixels in raster order and returns horizontal and vertical
// Sobel gradients with replicated borders, tagged with row and column.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    i_pixel
//   out       source     o_out_valid / i_out_stall  o_grad_x o_grad_y o_out_row
//                                                   o_out_col o_last
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// One pixel per cycle while each pixel completes at most one result and the
// output does not stall; a pixel completing more than one result holds the
// input while the emit stage sends them through its single output register.
// Results pass through the input register and line-store read, then the
// emit stage and its output register.
// Reset: counters to row 0, column 0, size 640 x 480, window cleared; the
// line stores are not cleared and take no clearing pass.
// A stall on the output backs up through the emit stage to o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_3x3_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic        [sg3_pkg::PIX_W-1:0]     i_pixel,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed      [sg3_pkg::GRAD_W-1:0]    o_grad_x,
    output logic signed      [sg3_pkg::GRAD_W-1:0]    o_grad_y,
    output logic             [sg3_pkg::OUT_ROW_W-1:0] o_out_row,
    output logic             [sg3_pkg::OUT_COL_W-1:0] o_out_col,
    output logic                                      o_last,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [sg3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [sg3_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]       w_last;
    logic [RW-1:0]       h_last;
    logic                restart;
    logic                ready;
    sg3_pkg::t_item_ctrl item;
    logic [RW-1:0]       item_row;
    logic [CW-1:0]       item_col;
    sg3_pkg::t_window    window;

    sg3_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_w_last    (w_last),
        .o_h_last    (h_last),
        .o_restart   (restart)
    );

    sg3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pixel    (i_pixel),
        .i_w_last   (w_last),
        .i_h_last   (h_last),
        .i_restart  (restart),
        .i_ready    (ready),
        .o_item     (item),
        .o_row      (item_row),
        .o_col      (item_col),
        .o_window   (window)
    );

    sg3_emit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_row       (item_row),
        .i_col       (item_col),
        .i_window    (window),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: tb/sobel_gradient_3x3_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient core testbench
// Streams pixels through the core under random idling on both channels and
// compares each gradient word with typed values or a behavioural predictor
// of the line stores, the window and the replicated borders. A short table
// of directed steps comes first, then random frames of many sizes.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3_core_tb;
    import sg3_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int GAP_MAX       = 17;
    localparam int RANDOM_PIXELS = 190;
    localparam int MIN_RESULTS   = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_DIRECTED  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = CFG_IMAGE_HEIGHT + 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST         = '1;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [OUT_ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0]     col;
        logic                     last;
    } grad_word_t;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_PIXEL,
        STEP_PIXEL_TYPED
    } step_kind_e;

    // typed rows: count words, all with gx/gy, starting at (at_row, at_col)
    // and moving along the row or down the column
    typedef struct packed {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   value;
        int                   count;
        int                   gx;
        int                   gy;
        int                   at_row;
        int                   at_col;
        bit                   along_row;
    } dir_step_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [PIX_W-1:0]      i_pixel     = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                        o_in_stall;
    logic                        o_out_valid;
    logic signed [GRAD_W-1:0]    o_grad_x;
    logic signed [GRAD_W-1:0]    o_grad_y;
    logic        [OUT_ROW_W-1:0] o_out_row;
    logic        [OUT_COL_W-1:0] o_out_col;
    logic                        o_last;
    logic                        o_cfg_ready;

    // predictor state
    logic [PIX_W-1:0]        row_above     [MAX_WIDTH];
    logic [PIX_W-1:0]        row_two_above [MAX_WIDTH];
    logic [PIX_W-1:0]        nbhd          [3][3];
    int                      next_col;
    int                      next_row;
    logic [CFG_WIDTH_W-1:0]  size_width;
    logic [CFG_HEIGHT_W-1:0] size_height;

    grad_word_t expected_grads [$];
    int         results_seen = 0;
    int         fail_count   = 0;
    int         cycle_count  = 0;
    int         random_sent  = 0;
    bit         send_steady  = 1'b0;

    dir_step_t directed_steps [NUM_DIRECTED] = '{
        // after reset the frame is 640 x 480: row 0 completes nothing
        '{STEP_PIXEL_TYPED, '0, 8'h00, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'hFF, 0, 0, 0, 0, 0, 1'b0},
        // one pixel frame: every pixel is its own flat neighbourhood
        '{STEP_CFG, CFG_IMAGE_WIDTH,  1, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 1, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'hA5, 1, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'h5A, 1, 0, 0, 0, 0, 1'b0},
        // two columns, one row: full swing on grad_x
        '{STEP_CFG, CFG_IMAGE_WIDTH,  2, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'h00, 0, 0,     0, 0, 0, 1'b1},
        '{STEP_PIXEL_TYPED, '0, 8'hFF, 2, 1020,  0, 0, 0, 1'b1},
        '{STEP_PIXEL_TYPED, '0, 8'hFF, 0, 0,     0, 0, 0, 1'b1},
        '{STEP_PIXEL_TYPED, '0, 8'h00, 2, -1020, 0, 0, 0, 1'b1},
        // one column, two rows: full swing on grad_y
        '{STEP_CFG, CFG_IMAGE_WIDTH,  1, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 2, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'h00, 0, 0, 0,     0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'hFF, 2, 0, 1020,  0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'hFF, 0, 0, 0,     0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'h00, 2, 0, -1020, 0, 0, 1'b0},
        // zero sizes act as one
        '{STEP_CFG, CFG_IMAGE_WIDTH,  0, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 0, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL_TYPED, '0, 8'h3C, 1, 0, 0, 0, 0, 1'b0},
        // 3 x 3 frame, with a write to an unknown index halfway through
        '{STEP_CFG, CFG_IMAGE_WIDTH,  3, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 3, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'h01, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'h80, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'hFE, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'h7F, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_CFG, CFG_IDX_LAST, 13'h1FFF, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'h55, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'hAA, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'h10, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'hEF, 0, 0, 0, 0, 0, 1'b0},
        '{STEP_PIXEL, '0, 8'h02, 0, 0, 0, 0, 0, 1'b0}
    };

    sobel_gradient_3x3_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int eff_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic grad_word_t gradient_at(input int y, input int x, input int r,
                                               input int c, input int w, input int h);
        int         p [3][3];
        int         ri, ci, gx, gy;
        grad_word_t g;
        // map each clamped neighbour onto the window around the newest pixel
        for (int i = 0; i < 3; i++) begin
            ri = clip(y + i - 1, h - 1) - r + 2;
            for (int j = 0; j < 3; j++) begin
                ci = clip(x + j - 1, w - 1) - c + 2;
                p[i][j] = (ri < 0 || ri > 2 || ci < 0 || ci > 2) ? 0 : int'(nbhd[ri][ci]);
            end
        end
        gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        g.grad_x = GRAD_W'(gx);
        g.grad_y = GRAD_W'(gy);
        g.row    = OUT_ROW_W'(y);
        g.col    = OUT_COL_W'(x);
        g.last   = 1'b0;
        return g;
    endfunction

    function automatic void predict_gradients(input logic [PIX_W-1:0] px,
                                              output grad_word_t res [$]);
        int w, h, c, r;
        int ys [$];
        int xs [$];
        w = eff_dim(size_width, MAX_WIDTH);
        h = eff_dim(size_height, MAX_HEIGHT);
        c = (next_col >= w) ? 0 : next_col;
        r = (next_row >= h) ? 0 : next_row;
        for (int i = 0; i < 3; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2]       = (r >= 2) ? row_two_above[c] : '0;
        nbhd[1][2]       = (r >= 1) ? row_above[c] : '0;
        nbhd[2][2]       = px;
        row_two_above[c] = row_above[c];
        row_above[c]     = px;
        // the pixel closes the one up-left of it, plus the row end and last row
        if (r >= 1) ys.push_back(r - 1);
        if (r == h - 1) ys.push_back(r);
        if (c >= 1) xs.push_back(c - 1);
        if (c == w - 1) xs.push_back(c);
        res = {};
        foreach (ys[i])
            foreach (xs[j])
                res.push_back(gradient_at(ys[i], xs[j], r, c, w, h));
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    // hold off the sender until every outstanding word is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_grads.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        // a pixel that completes nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: begin
                size_width = data[CFG_WIDTH_W-1:0];
                next_col   = 0;
                next_row   = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                size_height = data[CFG_HEIGHT_W-1:0];
                next_col    = 0;
                next_row    = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // valid stays high on return so back-to-back words need no toggle
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_checked(input logic [PIX_W-1:0] px);
        grad_word_t grads [$];
        send_pixel(px);
        predict_gradients(px, grads);
        foreach (grads[k]) expected_grads.push_back(grads[k]);
    endtask

    initial begin : result_sink
        int hold;
        bit steady;
        steady = 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) steady = !steady;
            hold = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        grad_word_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_grads.size() == 0) begin
                $error("unexpected word at row %0d col %0d", o_out_row, o_out_col);
                fail_count++;
            end else begin
                want = expected_grads.pop_front();
                if (o_grad_x !== want.grad_x) begin
                    $error("grad_x: expected %0d, got %0d", want.grad_x, o_grad_x);
                    fail_count++;
                end
                if (o_grad_y !== want.grad_y) begin
                    $error("grad_y: expected %0d, got %0d", want.grad_y, o_grad_y);
                    fail_count++;
                end
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                    fail_count++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        grad_word_t            g;
        grad_word_t            drop [$];
        dir_step_t             st;
        int                    phase, sel, n_pix, pause_at;
        logic [CFG_DATA_W-1:0] w_data, h_data;
        logic [PIX_W-1:0]      px;

        foreach (row_above[k]) row_above[k] = '0;
        foreach (row_two_above[k]) row_two_above[k] = '0;
        foreach (nbhd[i, j]) nbhd[i][j] = '0;
        next_col    = 0;
        next_row    = 0;
        size_width  = CFG_WIDTH_W'(WIDTH_RESET);
        size_height = CFG_HEIGHT_W'(HEIGHT_RESET);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) begin
            st = directed_steps[k];
            case (st.kind)
                STEP_CFG:   write_reg(st.reg_idx, st.value[CFG_DATA_W-1:0]);
                STEP_PIXEL: send_checked(st.value[PIX_W-1:0]);
                default: begin
                    send_pixel(st.value[PIX_W-1:0]);
                    predict_gradients(st.value[PIX_W-1:0], drop);
                    for (int j = 0; j < st.count; j++) begin
                        g.grad_x = GRAD_W'(st.gx);
                        g.grad_y = GRAD_W'(st.gy);
                        g.row    = OUT_ROW_W'(st.at_row + (st.along_row ? 0 : j));
                        g.col    = OUT_COL_W'(st.at_col + (st.along_row ? j : 0));
                        g.last   = (j == st.count - 1);
                        expected_grads.push_back(g);
                    end
                end
            endcase
        end

        phase = 0;
        while (random_sent < RANDOM_PIXELS || results_seen < MIN_RESULTS) begin
            sel    = (phase < 2) ? phase : $urandom_range(0, 9);
            w_data = {2'($urandom), 11'($urandom_range(1, 8))};
            h_data = 13'($urandom_range(1, 6));
            n_pix  = 0;
            case (sel)
                0: begin
                    // at least as wide as the line store: acts as the maximum
                    w_data = (phase == 0) ? '1
                           : {2'($urandom), 11'($urandom_range(MAX_WIDTH, 2047))};
                    h_data = 13'd1;
                    n_pix  = 40;
                end
                1: begin
                    h_data = (phase == 1) ? '1 : 13'($urandom_range(MAX_HEIGHT, 8191));
                    w_data[CFG_WIDTH_W-1:0] = 11'($urandom_range(1, 3));
                    n_pix  = 40;
                end
                2: begin
                    if ($urandom_range(0, 1) == 1) w_data[CFG_WIDTH_W-1:0] = '0;
                    else h_data = '0;
                end
                default: ;
            endcase
            if (n_pix == 0)
                n_pix = $urandom_range(1, 2 * eff_dim(w_data[CFG_WIDTH_W-1:0], MAX_WIDTH)
                                          * eff_dim(h_data, MAX_HEIGHT) + 2);

            write_reg(CFG_IMAGE_WIDTH, w_data);
            write_reg(CFG_IMAGE_HEIGHT, h_data);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_FIRST_UNUSED, CFG_IDX_LAST)),
                          CFG_DATA_W'($urandom));

            pause_at = $urandom_range(0, n_pix - 1);
            for (int k = 0; k < n_pix; k++) begin
                if (k == pause_at && k != 0) wait_drained();
                // bias towards black and white to reach the gradient extremes
                px = ($urandom_range(0, 3) == 0) ? {PIX_W{1'($urandom_range(0, 1))}}
                                                 : PIX_W'($urandom);
                send_checked(px);
                random_sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sg3_pkg.sv
rtl/core/sg3_ram.sv
rtl/core/sg3_cfg.sv
rtl/core/sg3_window.sv
rtl/core/sg3_emit.sv
rtl/core/sobel_gradient_3x3_core.sv
tb/sobel_gradient_3x3_core_tb.sv
